// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mtfpr_pkg.sv -----
// package with shared types and codes for the move-to-front position range core
package mtfpr_pkg;

    localparam logic [1:0] MODE_TOUCH   = 2'd0;
    localparam logic [1:0] MODE_QUERY   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam int FIELD_W = 6;

    // control broadcast to every cell
    typedef struct packed {
        logic restart;
        logic capture;
    } mtfpr_ctrl_t;

endpackage

// ----- hw/rtl/mtfpr_cell.sv -----
// one list position: holds an id with its least and greatest position
module mtfpr_cell
    import mtfpr_pkg::*;
#(
    parameter int PW  = 6,
    parameter int POS = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mtfpr_ctrl_t   ctrl,
    input  logic [PW-1:0] target,
    input  logic          take,
    input  logic [PW-1:0] in_id,
    input  logic [PW-1:0] in_least,
    input  logic [PW-1:0] in_greatest,
    output logic [PW-1:0] id,
    output logic [PW-1:0] least,
    output logic [PW-1:0] greatest,
    output logic          match
);

    localparam logic [PW-1:0] INIT = PW'(POS + 1);

    logic [PW-1:0] id_reg;
    logic [PW-1:0] least_reg;
    logic [PW-1:0] greatest_reg;
    logic          match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg       <= INIT;
            least_reg    <= INIT;
            greatest_reg <= INIT;
            match_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.restart)
            begin
                id_reg       <= INIT;
                least_reg    <= INIT;
                greatest_reg <= INIT;
            end
            else if (take)
            begin
                id_reg       <= in_id;
                least_reg    <= in_least;
                greatest_reg <= (in_greatest < INIT) ? INIT : in_greatest;
            end
            if (ctrl.capture)
            begin
                match_reg <= (id_reg == target);
            end
        end
    end

    assign id       = id_reg;
    assign least    = least_reg;
    assign greatest = greatest_reg;
    assign match    = match_reg;

endmodule

// ----- hw/rtl/move_to_front_position_range_core.sv -----
// a query result is registered: the cells capture the match on the input transfer, then the output registers load
// no new item is taken while one is in the cell row: compare on the input transfer, then shift while busy
// a query waits in the busy state while the previous result is still held
// reset: list restored to ids in order, items_in_use back to 32, no result pending
// top level: move-to-front list held in a row of cells with position tracking
module move_to_front_position_range_core
    import mtfpr_pkg::*;
#(
    parameter int MAX_ITEMS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // item_id[5:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // queried_id, least_position, greatest_position, pad
    output logic [0:0]  m_axis_tuser    // id_out_of_range
);

    localparam int PW = ($clog2(MAX_ITEMS + 1) > FIELD_W) ? $clog2(MAX_ITEMS + 1) : FIELD_W;
    localparam logic [PW-1:0] MAX_P   = PW'(MAX_ITEMS);
    localparam logic [PW-1:0] RESET_N = (MAX_ITEMS < 32) ? PW'(MAX_ITEMS) : PW'(32);

    logic [5:0]    items_in_use_reg;
    logic [PW-1:0] active_n_reg;
    logic          busy_reg;
    logic [1:0]    mode_reg;
    logic [PW-1:0] id_reg;
    logic          out_valid_reg;
    logic [5:0]    out_id_reg;
    logic [5:0]    out_least_reg;
    logic [5:0]    out_greatest_reg;
    logic          out_flag_reg;

    logic [PW-1:0] cell_id       [MAX_ITEMS];
    logic [PW-1:0] cell_least    [MAX_ITEMS];
    logic [PW-1:0] cell_greatest [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] match_vec;
    logic [MAX_ITEMS-1:0] take_vec;

    mtfpr_ctrl_t   ctrl;
    logic          accept;
    logic          id_valid;
    logic          done;
    logic          do_touch;
    logic [PW-1:0] sel_least;
    logic [PW-1:0] sel_greatest;
    logic [PW-1:0] n_cfg;
    logic [PW-1:0] n_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    assign id_valid = (id_reg != '0) && (id_reg <= active_n_reg);
    assign done     = (mode_reg != MODE_QUERY) || !out_valid_reg || m_axis_tready;
    assign do_touch = busy_reg && (mode_reg == MODE_TOUCH) && id_valid;

    assign ctrl.capture = accept;
    assign ctrl.restart = busy_reg && (mode_reg == MODE_RESTART);

    // clamp the configured length at restart
    assign n_cfg  = PW'(items_in_use_reg);
    assign n_next = (n_cfg == '0) ? PW'(1) : ((n_cfg > MAX_P) ? MAX_P : n_cfg);

    // pick the matched entry, match has at most one bit set
    always_comb
    begin
        sel_least    = '0;
        sel_greatest = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            if (match_vec[i])
            begin
                sel_least    = sel_least | cell_least[i];
                sel_greatest = sel_greatest | cell_greatest[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            assign take_vec[g] = do_touch && (|match_vec[MAX_ITEMS-1:g]);
            if (g == 0)
            begin : g_front
                mtfpr_cell #(.PW(PW), .POS(g)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .target      (PW'(s_axis_tdata[5:0])),
                    .take        (take_vec[g]),
                    .in_id       (id_reg),
                    .in_least    (PW'(1)),
                    .in_greatest (sel_greatest),
                    .id          (cell_id[g]),
                    .least       (cell_least[g]),
                    .greatest    (cell_greatest[g]),
                    .match       (match_vec[g])
                );
            end
            else
            begin : g_rest
                mtfpr_cell #(.PW(PW), .POS(g)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl),
                    .target      (PW'(s_axis_tdata[5:0])),
                    .take        (take_vec[g]),
                    .in_id       (cell_id[g-1]),
                    .in_least    (cell_least[g-1]),
                    .in_greatest (cell_greatest[g-1]),
                    .id          (cell_id[g]),
                    .least       (cell_least[g]),
                    .greatest    (cell_greatest[g]),
                    .match       (match_vec[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_in_use_reg <= 6'd32;
            active_n_reg     <= RESET_N;
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                items_in_use_reg <= cfg_wdata;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && done)
            begin
                busy_reg <= 1'b0;
            end
            if (ctrl.restart)
            begin
                active_n_reg <= n_next;
            end
            if (busy_reg && (mode_reg == MODE_QUERY) && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_axis_tuser;
            id_reg   <= PW'(s_axis_tdata[5:0]);
        end
        if (busy_reg && (mode_reg == MODE_QUERY) && done)
        begin
            out_id_reg       <= id_reg[5:0];
            out_least_reg    <= id_valid ? sel_least[5:0] : 6'd0;
            out_greatest_reg <= id_valid ? sel_greatest[5:0] : 6'd0;
            out_flag_reg     <= !id_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_greatest_reg, out_least_reg, out_id_reg};
    assign m_axis_tuser  = out_flag_reg;

endmodule

// ----- hw/rtl/mtfpr_checker.sv -----
// port-level checker for the move-to-front position range core, with its bind
`include "assert_macros.svh"

module mtfpr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wen,
    input logic [5:0]  cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an input transfer occupies the cell row for the next cycle
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // out of range result carries zero positions
    `ASSERT_SAME(a_bad_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[17:6] == 12'd0)

    // a good result never reports id zero
    `ASSERT_SAME(a_good_id, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[5:0] != 6'd0)

endmodule

bind move_to_front_position_range_core mtfpr_checker u_mtfpr_checker (.*);
